// ===== hdl/crar_pkg.sv =====
// Shared types and constants for the Catmull-Rom audio resampler.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
package crar_pkg;

    localparam int DEF_SAMPLE_FRAC_BITS = 8;
    localparam int DEF_PHASE_BITS       = 16;
    localparam int MAX_RUN              = 64;
    localparam int RUN_W                = 7;
    localparam int ACC_W                = 19;
    localparam int RATE_W               = 18;
    localparam int SCALE_W              = 21;
    localparam int CFG_DATA_W           = 21;
    localparam int CFG_INDEX_W          = 3;

    localparam logic [1:0] FMT_U8  = 2'd0;
    localparam logic [1:0] FMT_S16 = 2'd1;
    localparam logic [1:0] FMT_F32 = 2'd2;
    localparam logic [1:0] FMT_ALT = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] REG_IN_RATE     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OUT_RATE    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_SCALE = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_IN_FORMAT   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_IN_STEREO   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_OUT_STEREO  = 3'd5;

    // Commands from the sequencer to each lane
    typedef struct packed {
        logic       warm;
        logic [1:0] warm_sel;
        logic       push;
        logic       start;
    } lane_cmd_t;

endpackage

// ===== hdl/catmull_rom_audio_resampler.sv =====
// Catmull-Rom audio resampler. One input frame is taken per request; after three warm-up
// frames each frame gives zero to 64 output frames. Every output passes through the run
// check, phase multiply, phase limit, the six multiply/add steps of the cubic evaluator
// shared within each lane, and the hand-over to the output register. Each resampled frame
// adds acceptance, the closing run check and the history shift; warm-up frames are only
// accepted, and passthrough frames go from acceptance straight to the hand-over. Left and
// right lanes run side by side. A finished output waits in the output register while the
// next one is computed, and holds the sequencer only when the next one is ready before it
// is taken. Depends on crar_pkg, crar_conv, crar_lane, crar_merge.
module catmull_rom_audio_resampler #(
    parameter int SAMPLE_FRAC_BITS = crar_pkg::DEF_SAMPLE_FRAC_BITS,
    parameter int PHASE_BITS       = crar_pkg::DEF_PHASE_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [crar_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [crar_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [63:0]                        s_axis_tdata,  // sample_left, sample_right
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [31:0]                        m_axis_tdata,  // out_left, out_right
    output logic                               m_axis_tlast   // last_of_run
);
    localparam int HW = 18 + SAMPLE_FRAC_BITS;
    localparam int AW = 24 + SAMPLE_FRAC_BITS;
    localparam int PW = 40 - (32 - PHASE_BITS);
    localparam int ACC_W = crar_pkg::ACC_W;

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_PHASE, S_CLIP, S_RUN, S_EMIT, S_FINISH
    } state_t;

    state_t state_reg;
    logic [crar_pkg::RATE_W-1:0]  in_rate_reg, out_rate_reg;
    logic [crar_pkg::SCALE_W-1:0] scale_reg;
    logic [1:0]                   fmt_reg;
    logic                         in_st_reg, out_st_reg;
    logic [ACC_W-1:0]             acc_reg, acc_next;
    logic [1:0]                   warm_reg;
    logic [crar_pkg::RUN_W-1:0]   n_reg;
    logic [39:0]                  prod_reg;
    logic [PHASE_BITS:0]          p_reg;
    logic signed [HW-1:0]         sl_reg, sr_reg;
    logic [15:0]                  pass_l_reg, pass_r_reg;
    logic                         pass_reg;
    logic                         ov_reg, olast_reg;
    logic [15:0]                  ol_reg, or_reg;

    logic                 accept, passthru, out_free, last_now;
    logic signed [HW-1:0] conv_l, conv_r, lane_sl, lane_sr;
    logic [PW-1:0]        ph_raw;
    logic signed [AW-1:0] w_l, w_r;
    logic                 done_l, done_r;
    logic signed [15:0]   y_l, y_r;
    crar_pkg::lane_cmd_t  cmd_l, cmd_r;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign passthru = (fmt_reg == crar_pkg::FMT_S16) && (in_st_reg == out_st_reg)
                      && (in_rate_reg == out_rate_reg);
    assign out_free = !ov_reg || m_axis_tready;
    assign acc_next = acc_reg + ACC_W'(in_rate_reg);
    assign last_now = (n_reg == crar_pkg::RUN_W'(crar_pkg::MAX_RUN - 1))
                      || (acc_next >= ACC_W'(out_rate_reg));
    assign ph_raw   = prod_reg[39:32-PHASE_BITS];

    crar_conv #(.SAMPLE_FRAC_BITS(SAMPLE_FRAC_BITS)) u_conv_l (
        .raw(s_axis_tdata[31:0]), .fmt(fmt_reg), .sample(conv_l));
    crar_conv #(.SAMPLE_FRAC_BITS(SAMPLE_FRAC_BITS)) u_conv_r (
        .raw(s_axis_tdata[63:32]), .fmt(fmt_reg), .sample(conv_r));

    always_comb
    begin
        cmd_l.warm     = accept && !passthru && (warm_reg != 2'd3);
        cmd_l.warm_sel = warm_reg;
        cmd_l.push     = (state_reg == S_FINISH);
        cmd_l.start    = (state_reg == S_CLIP);
        cmd_r          = cmd_l;
        cmd_r.warm     = cmd_l.warm && in_st_reg;
        cmd_r.push     = cmd_l.push && in_st_reg;
    end

    assign lane_sl = cmd_l.warm ? conv_l : sl_reg;
    assign lane_sr = cmd_r.warm ? conv_r : sr_reg;

    crar_lane #(.SAMPLE_FRAC_BITS(SAMPLE_FRAC_BITS), .PHASE_BITS(PHASE_BITS)) u_lane_l (
        .clk(clk), .rst_n(rst_n), .cmd(cmd_l), .sample(lane_sl), .phase(p_reg),
        .w(w_l), .done(done_l));
    crar_lane #(.SAMPLE_FRAC_BITS(SAMPLE_FRAC_BITS), .PHASE_BITS(PHASE_BITS)) u_lane_r (
        .clk(clk), .rst_n(rst_n), .cmd(cmd_r), .sample(lane_sr), .phase(p_reg),
        .w(w_r), .done(done_r));

    crar_merge #(.SAMPLE_FRAC_BITS(SAMPLE_FRAC_BITS)) u_merge (
        .clk(clk), .load(state_reg == S_RUN && done_l), .in_stereo(in_st_reg),
        .out_stereo(out_st_reg), .w_left(w_l), .w_right(w_r),
        .y_left(y_l), .y_right(y_r));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_rate_reg  <= crar_pkg::RATE_W'(44100);
            out_rate_reg <= crar_pkg::RATE_W'(44100);
            scale_reg    <= crar_pkg::SCALE_W'(97392);
            fmt_reg      <= crar_pkg::FMT_S16;
            in_st_reg    <= 1'b1;
            out_st_reg   <= 1'b1;
            acc_reg      <= '0;
            warm_reg     <= 2'd0;
            n_reg        <= '0;
            prod_reg     <= '0;
            p_reg        <= '0;
            sl_reg       <= '0;
            sr_reg       <= '0;
            pass_l_reg   <= '0;
            pass_r_reg   <= '0;
            pass_reg     <= 1'b0;
            ov_reg       <= 1'b0;
            olast_reg    <= 1'b0;
            ol_reg       <= '0;
            or_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    crar_pkg::REG_IN_RATE:     in_rate_reg  <= cfg_data[17:0];
                    crar_pkg::REG_OUT_RATE:    out_rate_reg <= cfg_data[17:0];
                    crar_pkg::REG_PHASE_SCALE: scale_reg    <= cfg_data[20:0];
                    crar_pkg::REG_IN_FORMAT:
                        fmt_reg <= (cfg_data[1:0] == crar_pkg::FMT_ALT) ?
                                   crar_pkg::FMT_S16 : cfg_data[1:0];
                    crar_pkg::REG_IN_STEREO:   in_st_reg    <= cfg_data[0];
                    crar_pkg::REG_OUT_STEREO:  out_st_reg   <= cfg_data[0];
                    default: ;
                endcase
            end

            if (state_reg == S_EMIT && out_free)
                ov_reg <= 1'b1;
            else if (m_axis_tready)
                ov_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        pass_l_reg <= s_axis_tdata[15:0];
                        pass_r_reg <= in_st_reg ? s_axis_tdata[47:32] : s_axis_tdata[15:0];
                        sl_reg     <= conv_l;
                        sr_reg     <= conv_r;
                        n_reg      <= '0;
                        if (passthru)
                        begin
                            pass_reg  <= 1'b1;
                            state_reg <= S_EMIT;
                        end
                        else if (warm_reg != 2'd3)
                        begin
                            warm_reg <= warm_reg + 2'd1;
                        end
                        else
                        begin
                            pass_reg  <= 1'b0;
                            state_reg <= S_CHECK;
                        end
                    end
                end
                S_CHECK:
                begin
                    if (n_reg != crar_pkg::RUN_W'(crar_pkg::MAX_RUN)
                        && acc_reg < ACC_W'(out_rate_reg))
                        state_reg <= S_PHASE;
                    else
                        state_reg <= S_FINISH;
                end
                S_PHASE:
                begin
                    prod_reg  <= 40'(acc_reg) * 40'(scale_reg);
                    state_reg <= S_CLIP;
                end
                S_CLIP:
                begin
                    // phase limited to one full interval
                    if (ph_raw > (PW'(1) << PHASE_BITS))
                        p_reg <= (PHASE_BITS+1)'(1) << PHASE_BITS;
                    else
                        p_reg <= ph_raw[PHASE_BITS:0];
                    state_reg <= S_RUN;
                end
                S_RUN:
                begin
                    if (done_l)
                        state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        if (pass_reg)
                        begin
                            ol_reg    <= pass_l_reg;
                            or_reg    <= pass_r_reg;
                            olast_reg <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            ol_reg    <= y_l;
                            or_reg    <= y_r;
                            olast_reg <= last_now;
                            acc_reg   <= acc_next;
                            n_reg     <= n_reg + crar_pkg::RUN_W'(1);
                            state_reg <= S_CHECK;
                        end
                    end
                end
                S_FINISH:
                begin
                    acc_reg   <= (acc_reg >= ACC_W'(out_rate_reg)) ?
                                 acc_reg - ACC_W'(out_rate_reg) : '0;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {or_reg, ol_reg};
    assign m_axis_tlast  = olast_reg;

    a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        done_l == done_r) else $error("lanes out of step");
    a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        done_l |-> state_reg == S_RUN) else $error("lane finished outside run");
    a_run_limit: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= crar_pkg::RUN_W'(crar_pkg::MAX_RUN)) else $error("run limit exceeded");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && ov_reg && !m_axis_tready) |=> ov_reg && $stable(ol_reg))
        else $error("pending output overwritten");
endmodule

// ===== hdl/crar_conv.sv =====
// Raw sample to fixed-point history value (8-bit unsigned, 16-bit signed, single float).
// Depends on crar_pkg.
module crar_conv #(
    parameter int SAMPLE_FRAC_BITS = crar_pkg::DEF_SAMPLE_FRAC_BITS
) (
    input  logic [31:0]                    raw,
    input  logic [1:0]                     fmt,
    output logic signed [18+SAMPLE_FRAC_BITS-1:0] sample
);
    localparam int HW = 18 + SAMPLE_FRAC_BITS;
    localparam logic [38:0] LIM = 39'(1) << (17 + SAMPLE_FRAC_BITS);

    logic [7:0]        expo;
    logic [23:0]       mant;
    logic [38:0]       prod;
    logic signed [9:0] sh;
    logic [9:0]        shamt;
    logic [38:0]       mag;
    logic              big;
    logic signed [HW-1:0] fval;
    logic signed [HW-1:0] u8val;
    logic signed [HW-1:0] s16val;

    assign expo  = raw[30:23];
    assign mant  = {1'b1, raw[22:0]};
    // m * 32767
    assign prod  = ({mant, 15'd0}) - 39'(mant);
    assign sh    = $signed({2'b00, expo}) + 10'(SAMPLE_FRAC_BITS) - 10'sd150;
    assign shamt = -sh;

    always_comb
    begin
        big = 1'b0;
        mag = '0;
        if (expo == 8'hFF)
        begin
            big = 1'b1;
        end
        else if (sh >= 0)
        begin
            big = 1'b1;
        end
        else if (shamt < 10'd39)
        begin
            mag = prod >> shamt[5:0];
        end
        if (expo == 8'hFF && raw[22:0] != 23'd0)
        begin
            fval = '0;
        end
        else if (expo == 8'd0)
        begin
            fval = '0;
        end
        else if (raw[31])
        begin
            if (big || mag > LIM)
                fval = HW'(-$signed({1'b0, LIM}));
            else
                fval = HW'(-$signed({1'b0, mag}));
        end
        else
        begin
            if (big || mag >= LIM)
                fval = HW'(LIM - 39'd1);
            else
                fval = HW'(mag);
        end
    end

    assign u8val  = HW'($signed({1'b0, raw[7:0]}) - 10'sd128) <<< (8 + SAMPLE_FRAC_BITS);
    assign s16val = HW'($signed(raw[15:0])) <<< SAMPLE_FRAC_BITS;

    always_comb
    begin
        case (fmt)
            crar_pkg::FMT_U8:  sample = u8val;
            crar_pkg::FMT_F32: sample = fval;
            default:           sample = s16val;
        endcase
    end
endmodule

// ===== hdl/crar_lane.sv =====
// One channel lane: four-tap history and a cubic evaluator with one shared multiplier.
// Depends on crar_pkg (lane_cmd_t).
module crar_lane #(
    parameter int SAMPLE_FRAC_BITS = crar_pkg::DEF_SAMPLE_FRAC_BITS,
    parameter int PHASE_BITS       = crar_pkg::DEF_PHASE_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  crar_pkg::lane_cmd_t                  cmd,
    input  logic signed [18+SAMPLE_FRAC_BITS-1:0] sample,
    input  logic [PHASE_BITS:0]                  phase,
    output logic signed [24+SAMPLE_FRAC_BITS-1:0] w,
    output logic                                 done
);
    localparam int HW = 18 + SAMPLE_FRAC_BITS;
    localparam int AW = 24 + SAMPLE_FRAC_BITS;
    localparam int MW = AW + PHASE_BITS + 2;
    localparam logic signed [HW+1:0] HMAX = (HW+2)'((1 <<< (HW-1)) - 1);
    localparam logic signed [HW+1:0] HMIN = -(HW+2)'(1 <<< (HW-1));

    logic signed [HW-1:0] hist_reg [4];
    logic signed [AW-1:0] x0, x1, x2, x3;
    logic signed [AW-1:0] coef_a, coef_b, coef_c, coef_d;
    logic signed [AW-1:0] acc_reg, b_reg, c_reg, d_reg, addend;
    logic signed [MW-1:0] m_reg, prod, scaled;
    logic signed [HW+1:0] extrap;
    logic [2:0]           step_reg;
    logic                 done_reg;

    assign extrap = ((HW+2)'(hist_reg[1]) <<< 1) - (HW+2)'(sample);

    always_ff @(posedge clk)
    begin
        if (cmd.warm)
        begin
            case (cmd.warm_sel)
                2'd0: hist_reg[1] <= sample;
                2'd1:
                begin
                    hist_reg[2] <= sample;
                    // x0 extrapolated back from x1 and x2
                    if (extrap > HMAX)
                        hist_reg[0] <= HW'(HMAX);
                    else if (extrap < HMIN)
                        hist_reg[0] <= HW'(HMIN);
                    else
                        hist_reg[0] <= HW'(extrap);
                end
                default: hist_reg[3] <= sample;
            endcase
        end
        else if (cmd.push)
        begin
            hist_reg[0] <= hist_reg[1];
            hist_reg[1] <= hist_reg[2];
            hist_reg[2] <= hist_reg[3];
            hist_reg[3] <= sample;
        end
    end

    assign x0 = AW'(hist_reg[0]);
    assign x1 = AW'(hist_reg[1]);
    assign x2 = AW'(hist_reg[2]);
    assign x3 = AW'(hist_reg[3]);
    assign coef_a = AW'(3) * (x1 - x2) + (x3 - x0);
    assign coef_b = AW'(2) * x0 - AW'(5) * x1 + AW'(4) * x2 - x3;
    assign coef_c = x2 - x0;
    assign coef_d = AW'(2) * x1;

    assign prod   = MW'(acc_reg) * MW'($signed({1'b0, phase}));
    assign scaled = m_reg >>> PHASE_BITS;

    always_comb
    begin
        case (step_reg)
            3'd2:    addend = b_reg;
            3'd4:    addend = c_reg;
            default: addend = d_reg;
        endcase
    end

    // Horner: odd steps multiply by the phase, even steps add the next coefficient
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            acc_reg <= coef_a;
            b_reg   <= coef_b;
            c_reg   <= coef_c;
            d_reg   <= coef_d;
        end
        else if (step_reg[0])
        begin
            m_reg <= prod;
        end
        else if (step_reg != 3'd0)
        begin
            acc_reg <= addend + AW'(scaled);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 3'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (step_reg == 3'd6);
            if (cmd.start)
                step_reg <= 3'd1;
            else if (step_reg == 3'd6)
                step_reg <= 3'd0;
            else if (step_reg != 3'd0)
                step_reg <= step_reg + 3'd1;
        end
    end

    assign w    = acc_reg;
    assign done = done_reg;
endmodule

// ===== hdl/crar_merge.sv =====
// Merging stage: scales and clamps the lane results, downmixes or duplicates channels.
// Depends on crar_pkg.
module crar_merge #(
    parameter int SAMPLE_FRAC_BITS = crar_pkg::DEF_SAMPLE_FRAC_BITS
) (
    input  logic                                  clk,
    input  logic                                  load,
    input  logic                                  in_stereo,
    input  logic                                  out_stereo,
    input  logic signed [24+SAMPLE_FRAC_BITS-1:0] w_left,
    input  logic signed [24+SAMPLE_FRAC_BITS-1:0] w_right,
    output logic signed [15:0]                    y_left,
    output logic signed [15:0]                    y_right
);
    localparam int AW = 24 + SAMPLE_FRAC_BITS;
    localparam int K1 = 1 + SAMPLE_FRAC_BITS;
    localparam int K2 = 2 + SAMPLE_FRAC_BITS;

    logic signed [AW-1:0] tl1, tr1, tl2, tr2;
    logic signed [15:0]   cl1, cr1, cl2, cr2, sum_sat;
    logic signed [16:0]   sum;
    logic signed [15:0]   yl_reg, yr_reg;

    function automatic logic signed [AW-1:0] trunc_div(input logic signed [AW-1:0] x,
                                                        input int k);
        logic signed [AW-1:0] bias;
        bias = (AW'(1) <<< k) - AW'(1);
        return (x < 0) ? ((x + bias) >>> k) : (x >>> k);
    endfunction

    function automatic logic signed [15:0] clamp16(input logic signed [AW-1:0] x);
        if (x > AW'(32767))
            return 16'sh7FFF;
        else if (x < -AW'(32768))
            return 16'sh8000;
        else
            return 16'(x);
    endfunction

    assign tl1 = trunc_div(w_left, K1);
    assign tr1 = trunc_div(w_right, K1);
    assign tl2 = trunc_div(w_left, K2);
    assign tr2 = trunc_div(w_right, K2);
    assign cl1 = clamp16(tl1);
    assign cr1 = clamp16(tr1);
    assign cl2 = clamp16(tl2);
    assign cr2 = clamp16(tr2);
    assign sum = 17'(cl2) + 17'(cr2);
    assign sum_sat = (sum > 17'sd32767) ? 16'sh7FFF :
                     (sum < -17'sd32768) ? 16'sh8000 : 16'(sum);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (in_stereo && !out_stereo)
            begin
                yl_reg <= sum_sat;
                yr_reg <= sum_sat;
            end
            else
            begin
                yl_reg <= cl1;
                yr_reg <= (in_stereo && out_stereo) ? cr1 : cl1;
            end
        end
    end

    assign y_left  = yl_reg;
    assign y_right = yr_reg;
endmodule

// ===== bench/catmull_rom_audio_resampler_test.sv =====
// Testbench for catmull_rom_audio_resampler: streams audio frames through the block
// and compares every output frame with a cycle-free cubic resampling predictor.
// Depends on crar_pkg and the RTL under hdl/.
`timescale 1ns / 1ps

module catmull_rom_audio_resampler_test;

    localparam int  LIMIT_CYCLES = 5_000_000;
    localparam int  ITEM_TARGET  = 430;
    localparam longint HIST_LIM  = longint'(1) << 25;

    class resample_scoreboard;
        typedef struct {
            logic [15:0] left;
            logic [15:0] right;
            logic        last;
        } out_frame_t;

        out_frame_t  pending[$];
        int          errors;
        bit [17:0]   in_rate     = 44100;
        bit [17:0]   out_rate    = 44100;
        bit [20:0]   phase_scale = 97392;
        bit [1:0]    fmt         = crar_pkg::FMT_S16;
        bit          in_st       = 1;
        bit          out_st      = 1;
        longint      hl[4];
        longint      hr[4];
        bit [18:0]   acc;
        int          warm_n;

        function void write_reg(logic [crar_pkg::CFG_INDEX_W-1:0] idx,
                                logic [crar_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                crar_pkg::REG_IN_RATE:     in_rate = val[17:0];
                crar_pkg::REG_OUT_RATE:    out_rate = val[17:0];
                crar_pkg::REG_PHASE_SCALE: phase_scale = val[20:0];
                crar_pkg::REG_IN_FORMAT:
                    fmt = (val[1:0] == crar_pkg::FMT_ALT) ? crar_pkg::FMT_S16 : val[1:0];
                crar_pkg::REG_IN_STEREO:   in_st = val[0];
                crar_pkg::REG_OUT_STEREO:  out_st = val[0];
                default: ;
            endcase
        endfunction

        function longint sat_hist(longint v);
            if (v >= HIST_LIM) return HIST_LIM - 1;
            if (v < -HIST_LIM) return -HIST_LIM;
            return v;
        endfunction

        function longint clamp16(longint v);
            return (v < -32768) ? -32768 : (v > 32767) ? 32767 : v;
        endfunction

        function longint to_fixed(bit [31:0] raw);
            bit [7:0]  e;
            bit [23:0] m;
            longint    prod;
            longint    mag;
            int        s;
            if (fmt == crar_pkg::FMT_U8) return (longint'(raw[7:0]) - 128) * 256 * 256;
            if (fmt == crar_pkg::FMT_S16) return longint'($signed(raw[15:0])) * 256;
            e = raw[30:23];
            m = {1'b1, raw[22:0]};
            if (e == 8'hFF)
            begin
                if (raw[22:0] != 0) return 0;
                mag = HIST_LIM;
            end
            else if (e == 0)
            begin
                return 0;   // subnormal
            end
            else
            begin
                prod = longint'(m) * 32767;
                s = int'(e) - 150 + 8;
                if (s >= 0) mag = HIST_LIM;
                else mag = (-s >= 63) ? 0 : (prod >> (-s));
            end
            if (raw[31]) return (mag > HIST_LIM) ? -HIST_LIM : -mag;
            return (mag >= HIST_LIM) ? HIST_LIM - 1 : mag;
        endfunction

        function longint cubic(longint h[4], longint p, int k);
            longint a, b, c, d, u, v, w;
            a = 3 * (h[1] - h[2]) + (h[3] - h[0]);
            b = 2 * h[0] - 5 * h[1] + 4 * h[2] - h[3];
            c = h[2] - h[0];
            d = 2 * h[1];
            u = b + ((a * p) >>> 16);
            v = c + ((u * p) >>> 16);
            w = d + ((v * p) >>> 16);
            return w / (longint'(1) << k);
        endfunction

        function void note_frame(bit [31:0] raw_l, bit [31:0] raw_r);
            longint     sl, sr, p, yl, yr;
            longint     ph;
            int         n;
            out_frame_t f;
            if (fmt == crar_pkg::FMT_S16 && in_st == out_st && in_rate == out_rate)
            begin
                f.left  = raw_l[15:0];
                f.right = in_st ? raw_r[15:0] : raw_l[15:0];
                f.last  = 1;
                pending.push_back(f);
                return;
            end
            sl = to_fixed(raw_l);
            sr = in_st ? to_fixed(raw_r) : 0;
            if (warm_n < 3)
            begin
                case (warm_n)
                    0:
                    begin
                        hl[1] = sl;
                        if (in_st) hr[1] = sr;
                    end
                    1:
                    begin
                        hl[2] = sl;
                        hl[0] = sat_hist(2 * hl[1] - hl[2]);
                        if (in_st)
                        begin
                            hr[2] = sr;
                            hr[0] = sat_hist(2 * hr[1] - hr[2]);
                        end
                    end
                    default:
                    begin
                        hl[3] = sl;
                        if (in_st) hr[3] = sr;
                    end
                endcase
                warm_n++;
                return;
            end
            n = 0;
            while (n < crar_pkg::MAX_RUN && acc < out_rate)
            begin
                ph = (longint'(acc) * longint'(phase_scale)) >> 16;
                if (ph > 65536) ph = 65536;
                p = ph;
                if (in_st && !out_st)
                begin
                    yl = clamp16(cubic(hl, p, 10));
                    yr = clamp16(cubic(hr, p, 10));
                    yl = clamp16(yl + yr);
                    yr = yl;
                end
                else
                begin
                    yl = clamp16(cubic(hl, p, 9));
                    yr = (in_st && out_st) ? clamp16(cubic(hr, p, 9)) : yl;
                end
                f.left  = yl[15:0];
                f.right = yr[15:0];
                f.last  = 0;
                pending.push_back(f);
                n++;
                acc = 19'(acc + in_rate);
            end
            if (n > 0) pending[pending.size() - 1].last = 1;
            hl = '{hl[1], hl[2], hl[3], sl};
            if (in_st) hr = '{hr[1], hr[2], hr[3], sr};
            acc = (acc >= out_rate) ? acc - out_rate : 19'd0;
        endfunction

        function void check_frame(logic [31:0] d, logic last);
            out_frame_t e;
            if (pending.size() == 0)
            begin
                $error("output frame with nothing expected: %h last %b", d, last);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (d[15:0] !== e.left)
            begin
                $error("out_left expected %0d got %0d", $signed(e.left), $signed(d[15:0]));
                errors++;
            end
            if (d[31:16] !== e.right)
            begin
                $error("out_right expected %0d got %0d", $signed(e.right), $signed(d[31:16]));
                errors++;
            end
            if (last !== e.last)
            begin
                $error("last_of_run expected %b got %b", e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                              clk = 0;
    logic                              rst_n = 0;
    logic                              cfg_we = 0;
    logic [crar_pkg::CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [crar_pkg::CFG_DATA_W-1:0]   cfg_data = '0;
    logic                              s_axis_tvalid = 0;
    logic                              s_axis_tready;
    logic [63:0]                       s_axis_tdata = '0;   // sample_left, sample_right
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 0;
    logic [31:0]                       m_axis_tdata;        // out_left, out_right
    logic                              m_axis_tlast;        // last_of_run

    resample_scoreboard sb = new();
    int  cycles;
    int  sent;
    int  send_pct;
    int  recv_pct = 46;
    int  hold_left;
    bit  hold_req;

    catmull_rom_audio_resampler dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // output side: check, then pick tready (long hold-off on request)
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_frame(m_axis_tdata, m_axis_tlast);
            if (hold_req)
            begin
                hold_req = 0;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= recv_pct);
            end
        end
    end

    task automatic send_frame(bit [31:0] l, bit [31:0] r);
        while ($urandom_range(99) < send_pct)
        begin
            s_axis_tvalid <= 0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {r, l};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        sb.note_frame(l, r);
        sent++;
        // idling pattern swaps by thirds of the run
        if (sent < ITEM_TARGET / 3)
        begin
            send_pct = 34; recv_pct = 46;
        end
        else if (sent < 2 * ITEM_TARGET / 3)
        begin
            send_pct = 46; recv_pct = 34;
        end
        else
        begin
            send_pct = 0; recv_pct = 0;
        end
    endtask

    task automatic configure(bit [1:0] fmt, bit ist, bit ost, int inr, int outr);
        longint scale;
        scale = ((longint'(1) << 32) + outr / 2) / outr;
        s_axis_tvalid <= 0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);  // warm-up frames give nothing to wait on
        for (int i = 0; i < 6; i++)
        begin
            cfg_we    <= 1;
            cfg_index <= crar_pkg::CFG_INDEX_W'(i);
            case (i)
                0: cfg_data <= crar_pkg::CFG_DATA_W'(inr);
                1: cfg_data <= crar_pkg::CFG_DATA_W'(outr);
                2: cfg_data <= crar_pkg::CFG_DATA_W'(scale);
                3: cfg_data <= crar_pkg::CFG_DATA_W'(fmt);
                4: cfg_data <= crar_pkg::CFG_DATA_W'(ist);
                default: cfg_data <= crar_pkg::CFG_DATA_W'(ost);
            endcase
            @(posedge clk);
            sb.write_reg(cfg_index, cfg_data);
        end
        cfg_we <= 0;
        @(posedge clk);
    endtask

    function automatic bit [31:0] random_sample(bit [1:0] fmt);
        bit [31:0] w;
        w = $urandom;
        // mostly sensible floats; the rest raw bit noise
        if (fmt == crar_pkg::FMT_F32 && $urandom_range(9) < 8)
            w[30:23] = 8'($urandom_range(112, 127));
        return w;
    endfunction

    function automatic int random_rate();
        case ($urandom_range(7))
            0: return 4000;
            1: return 256000;
            default: return $urandom_range(4000, 256000);
        endcase
    endfunction

    initial
    begin
        bit [1:0] fmt;
        bit       ist, ost;
        int       inr, outr, n;
        bit       pressed;

        send_pct = 34;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // passthrough at reset settings
        send_frame(32'h0000_7FFF, 32'hFFFF_8000);
        send_frame(32'hFFFF_8000, 32'h0000_7FFF);
        send_frame(32'h0, 32'hFFFF_FFFF);

        // warm-up in stereo so both histories are filled, then 16-bit extremes
        configure(crar_pkg::FMT_S16, 1, 1, 44100, 48000);
        send_frame(32'h0000_0000, 32'h0000_0000);
        send_frame(32'hABCD_7FFF, 32'h1234_8000);
        send_frame(32'h5555_8000, 32'h0000_7FFF);
        send_frame(32'h0000_7FFF, 32'hFFFF_8000);
        send_frame(32'h0000_8000, 32'h0000_7FFF);

        // float specials, downmixed
        configure(crar_pkg::FMT_F32, 1, 0, 48000, 44100);
        send_frame(32'h7FC0_0000, 32'h7F80_0000);   // NaN, +inf
        send_frame(32'hFF80_0000, 32'h0000_0001);   // -inf, subnormal
        send_frame(32'h3F80_0000, 32'hBF80_0000);   // +1, -1
        send_frame(32'h501502F9, 32'hD01502F9);    // huge values
        send_frame(32'h3F80_0000, 32'h3F80_0000);   // both full scale

        // 8-bit mono to stereo at the longest run
        configure(crar_pkg::FMT_U8, 0, 1, 4000, 256000);
        send_frame(32'h0000_00FF, 32'h0);
        send_frame(32'hFFFF_FF00, 32'h0);
        send_frame(32'h0000_0080, 32'h0);

        // alternate format code: mono passthrough, then resampled
        configure(crar_pkg::FMT_ALT, 0, 0, 32000, 32000);
        send_frame(32'h0000_8000, 32'hFFFF_FFFF);
        send_frame(32'hFFFF_7FFF, 32'h0);
        configure(crar_pkg::FMT_ALT, 1, 1, 256000, 4000);
        send_frame(32'h0000_7FFF, 32'h0000_8000);
        send_frame(32'h0000_8000, 32'h0000_7FFF);

        pressed = 0;
        while (sent < ITEM_TARGET)
        begin
            fmt  = 2'($urandom_range(3));
            ist  = $urandom_range(1);
            ost  = $urandom_range(1);
            inr  = random_rate();
            outr = ($urandom_range(4) == 0) ? inr : random_rate();
            configure(fmt, ist, ost, inr, outr);
            n = (outr / inr > 8) ? 4 : $urandom_range(15, 35);
            if (send_pct == 0 && !pressed)
            begin
                hold_req = 1;
                pressed = 1;
                n = 40;
            end
            repeat (n) send_frame(random_sample(fmt), random_sample(fmt));
        end

        s_axis_tvalid <= 0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// ===== catmull_rom_audio_resampler.f =====
hdl/crar_pkg.sv
hdl/crar_conv.sv
hdl/crar_lane.sv
hdl/crar_merge.sv
hdl/catmull_rom_audio_resampler.sv
bench/catmull_rom_audio_resampler_test.sv
